@@ rtl/i2p_pkg.sv @@
// i2p_pkg: shared constants, codes, precedence functions and control structs
// for the infix-to-postfix converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2p_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = $clog2(STACK_DEPTH);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_POW   = 8'h5E;

	typedef enum logic [2:0] {
		OP_LPAR  = 3'd0,
		OP_PLUS  = 3'd1,
		OP_MINUS = 3'd2,
		OP_MUL   = 3'd3,
		OP_DIV   = 3'd4,
		OP_POW   = 3'd5
	} op_code_t;

	typedef enum logic [1:0] {
		SEL_TOP  = 2'd0,
		SEL_SYM  = 2'd1,
		SEL_NUL  = 2'd2,
		SEL_RPAR = 2'd3
	} emit_sel_t;

	typedef struct packed {
		logic      load;
		logic      emit;
		emit_sel_t sel;
		logic      err;
		logic      pop;
		logic      push;
		logic      flush;
	} dp_cmd_t;

	typedef struct packed {
		logic is_nul;
		logic is_rpar;
		logic is_lpar;
		logic is_op;
		logic empty;
		logic full;
		logic top_lpar;
		logic pop_prec;
		logic emit_ok;
		logic pend_valid;
		logic out_free;
	} dp_stat_t;

	// binary operators only; brackets are handled separately
	function automatic logic is_binop(input logic [7:0] s);
		return (s == CH_PLUS) || (s == CH_MINUS) || (s == CH_MUL) ||
			(s == CH_DIV) || (s == CH_POW);
	endfunction

	function automatic op_code_t op_of(input logic [7:0] s);
		op_code_t r;
		unique case (s)
			CH_PLUS:  r = OP_PLUS;
			CH_MINUS: r = OP_MINUS;
			CH_MUL:   r = OP_MUL;
			CH_DIV:   r = OP_DIV;
			CH_POW:   r = OP_POW;
			default:  r = OP_LPAR;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] char_of(input op_code_t op);
		logic [7:0] r;
		unique case (op)
			OP_LPAR:  r = CH_LPAR;
			OP_PLUS:  r = CH_PLUS;
			OP_MINUS: r = CH_MINUS;
			OP_MUL:   r = CH_MUL;
			OP_DIV:   r = CH_DIV;
			OP_POW:   r = CH_POW;
			default:  r = CH_NUL;
		endcase
		return r;
	endfunction

	// in-stack precedence
	function automatic logic [2:0] isp_of(input op_code_t op);
		logic [2:0] r;
		unique case (op) inside
			OP_PLUS, OP_MINUS: r = 3'd1;
			OP_MUL, OP_DIV:    r = 3'd2;
			OP_POW:            r = 3'd3;
			default:           r = 3'd0;
		endcase
		return r;
	endfunction

	// incoming precedence; '^' above its own stacked value for right assoc
	function automatic logic [2:0] icp_of(input op_code_t op);
		logic [2:0] r;
		unique case (op) inside
			OP_PLUS, OP_MINUS: r = 3'd1;
			OP_MUL, OP_DIV:    r = 3'd2;
			OP_POW:            r = 3'd4;
			default:           r = 3'd5;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/i2p_dp.sv @@
// i2p_dp: datapath of the converter: symbol register, operator stack,
// one-entry pending result and the output register. Uses i2p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2p_dp import i2p_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] symbol,
	input  wire dp_cmd_t    cmd,
	output dp_stat_t        stat,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_symbol,
	output logic            last,
	output logic            error
);

	logic [7:0]       sym_q;
	op_code_t         stack_q [STACK_DEPTH];
	logic [CNT_W-1:0] count_q;
	logic             pend_valid_q;
	logic [7:0]       pend_sym_q;
	logic             pend_err_q;
	logic             out_valid_q;
	logic [7:0]       out_sym_q;
	logic             out_last_q;
	logic             out_err_q;

	logic [CNT_W-1:0] cnt_m1;
	op_code_t         top;
	op_code_t         sym_op;
	logic [7:0]       emit_sym;
	logic             out_free;
	logic             xfer;

	assign cnt_m1   = count_q - 1'b1;
	assign top      = stack_q[cnt_m1[IDX_W-1:0]];
	assign sym_op   = op_of(sym_q);
	assign out_free = !out_valid_q || out_ready;
	// pending result moves on when a new one arrives, or at the end of the item
	assign xfer     = (cmd.emit && pend_valid_q) || cmd.flush;

	always_comb begin
		case (cmd.sel)
			SEL_TOP:  emit_sym = char_of(top);
			SEL_SYM:  emit_sym = sym_q;
			SEL_NUL:  emit_sym = CH_NUL;
			SEL_RPAR: emit_sym = CH_RPAR;
			default:  emit_sym = CH_NUL;
		endcase
	end

	always_comb begin
		stat.is_nul     = (sym_q == CH_NUL);
		stat.is_rpar    = (sym_q == CH_RPAR);
		stat.is_lpar    = (sym_q == CH_LPAR);
		stat.is_op      = is_binop(sym_q);
		stat.empty      = (count_q == '0);
		stat.full       = (count_q == CNT_W'(STACK_DEPTH));
		stat.top_lpar   = (top == OP_LPAR);
		stat.pop_prec   = (icp_of(sym_op) <= isp_of(top));
		stat.emit_ok    = !pend_valid_q || out_free;
		stat.pend_valid = pend_valid_q;
		stat.out_free   = out_free;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sym_q <= symbol;
		end
		if (cmd.push) begin
			stack_q[count_q[IDX_W-1:0]] <= sym_op;
		end
		if (cmd.emit) begin
			pend_sym_q <= emit_sym;
			pend_err_q <= cmd.err;
		end
		if (xfer) begin
			out_sym_q  <= pend_sym_q;
			out_err_q  <= pend_err_q;
			out_last_q <= cmd.flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.pop) begin
				count_q <= cnt_m1;
			end
			if (cmd.emit) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (xfer) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_symbol = out_sym_q;
	assign last       = out_last_q;
	assign error      = out_err_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> count_q != '0)
		else $error("pop from empty stack");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> count_q != CNT_W'(STACK_DEPTH))
		else $error("push onto full stack");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		xfer |-> pend_valid_q && out_free)
		else $error("output beat overwritten or empty transfer");

	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.pop))
		else $error("push and pop in one cycle");

endmodule

`default_nettype wire

@@ rtl/i2p_ctrl.sv @@
// i2p_ctrl: converter control state machine; steps one stack action per
// cycle unless output stalls; issues datapath commands. Uses i2p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2p_ctrl import i2p_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     valid,
	output logic          ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_WORK  = 3'b010,
		S_FLUSH = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		cmd.sel = SEL_TOP;
		state_d = state_q;
		ready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				ready    = 1'b1;
				cmd.load = valid;
				if (valid) begin
					state_d = S_WORK;
				end
			end
			S_WORK: begin
				if (stat.is_nul) begin
					// end of expression: drain stack, then terminator
					if (!stat.empty) begin
						if (stat.emit_ok) begin
							cmd.emit = 1'b1;
							cmd.pop  = 1'b1;
						end
					end else if (stat.emit_ok) begin
						cmd.emit = 1'b1;
						cmd.sel  = SEL_NUL;
						state_d  = S_FLUSH;
					end
				end else if (stat.is_rpar) begin
					if (stat.empty) begin
						// unmatched ')'
						if (stat.emit_ok) begin
							cmd.emit = 1'b1;
							cmd.sel  = SEL_RPAR;
							cmd.err  = 1'b1;
							state_d  = S_FLUSH;
						end
					end else if (stat.top_lpar) begin
						cmd.pop = 1'b1;
						state_d = S_FLUSH;
					end else if (stat.emit_ok) begin
						cmd.emit = 1'b1;
						cmd.pop  = 1'b1;
					end
				end else if (stat.is_op || stat.is_lpar) begin
					if (stat.is_op && !stat.empty && stat.pop_prec) begin
						if (stat.emit_ok) begin
							cmd.emit = 1'b1;
							cmd.pop  = 1'b1;
						end
					end else if (!stat.full) begin
						cmd.push = 1'b1;
						state_d  = S_FLUSH;
					end else if (stat.emit_ok) begin
						// dropped push
						cmd.emit = 1'b1;
						cmd.sel  = SEL_SYM;
						cmd.err  = 1'b1;
						state_d  = S_FLUSH;
					end
				end else if (stat.emit_ok) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_SYM;
					state_d  = S_FLUSH;
				end
			end
			S_FLUSH: begin
				// final pending beat goes out marked last
				if (!stat.pend_valid) begin
					state_d = S_IDLE;
				end else if (stat.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_WORK)
		else $error("load did not start work");

	a_flush_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> state_q == S_IDLE)
		else $error("flush did not return to idle");

	a_stack_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push || cmd.pop || cmd.emit) |-> state_q == S_WORK)
		else $error("stack or emit command outside work");

endmodule

`default_nettype wire

@@ rtl/infix_to_postfix_converter.sv @@
// infix_to_postfix_converter: top level; joins the controller and datapath.
// Depends on i2p_pkg, i2p_ctrl, i2p_dp.
//
//   channel   signals                                 dir  beat
//   input     valid, ready, symbol[7:0]               in   one infix character
//   output    out_valid, out_ready, out_symbol[7:0],  out  one postfix character
//             last, error
//
// A character is accepted only when the controller is idle. Work steps through
// each stack pop or emitted result in turn, then releases the final beat with
// last set. Results pass through a one-entry pending stage into the output
// register, so the next character can be accepted while the last beat still
// waits. A stall on out_ready holds the stack walk; reset clears stack count
// and valid flags, the stack itself is never cleared.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter import i2p_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       valid,
	output logic            ready,
	input  wire logic [7:0] symbol,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_symbol,
	output logic            last,
	output logic            error
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	i2p_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid),
		.ready  (ready),
		.stat   (stat),
		.cmd    (cmd)
	);

	i2p_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.symbol     (symbol),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_symbol (out_symbol),
		.last       (last),
		.error      (error)
	);

endmodule

`default_nettype wire
